// ----- rtl/core/min_heap_priority_queue_macros.svh -----
// Assertion macros shared by the min-heap priority queue checkers.
// No dependencies; included by the checker file.
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Clocked property that is ignored while reset is high
`define MHPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that also holds through reset
`define MHPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and codes of the min-heap priority queue.
// No dependencies; imported by every module of the block.
package mhpq_pkg;

   localparam int TIME_W   = 31;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic              func;
      logic [TIME_W-1:0] start_stamp;
      logic [TIME_W-1:0] end_stamp;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]   top_start;
      logic [TIME_W-1:0]   top_end;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // one heap slot: payload and key
   typedef struct packed {
      logic [TIME_W-1:0] start_stamp;
      logic [TIME_W-1:0] end_stamp;
   } entry_type;

endpackage

// ----- rtl/core/mhpq_store.sv -----
// Heap entry memory: one write port, two registered read ports.
// Depends on mhpq_pkg for the entry type.
module mhpq_store #(
   parameter int HEAP_DEPTH = 1024,
   parameter int AW         = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  mhpq_pkg::entry_type   wr_data,
   input  logic [AW-1:0]         rd_a_addr,
   input  logic [AW-1:0]         rd_b_addr,
   output mhpq_pkg::entry_type   rd_a_data,
   output mhpq_pkg::entry_type   rd_b_data
);
   import mhpq_pkg::*;

   entry_type mem [HEAP_DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // write one slot, read two slots into registered outputs
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- rtl/core/min_heap_priority_queue.sv -----
// Top level of the min-heap priority queue of intervals keyed on end time.
// Depends on mhpq_pkg and mhpq_store.
//
// A request (push or pop) is taken when start is high and busy is low; busy
// stays high until the result is out. Exactly one result follows each request
// and is shown for one cycle with rsp_strobe; the receiver cannot stall it and
// must take it on that cycle. A push reads and compares the parent on each
// level it climbs; a pop first reads the last entry into the root, then reads
// and compares the children on each level it sinks; a full push, an empty pop
// or a pop that empties the heap goes straight to the result. The result shows
// in the same cycle as busy falls, and the next request can be taken in that
// same cycle. At the default depth of 1024 the longest request is a push into
// the last slot, which climbs 10 levels. Each heap level is a read-compare-write
// through the entry memory, whose read data arrive in the cycle after the
// address. Entries are not cleared at reset and need no clearing pass: only
// slots below the fill count are read.
module min_heap_priority_queue #(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhpq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mhpq_pkg::rsp_type rsp_item
);
   import mhpq_pkg::*;

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int XW = AW + 2;
   localparam int EW = CW + COUNT_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_RD   = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DN_LAST = 3'd3;
   localparam logic [2:0] S_DN_RD   = 3'd4;
   localparam logic [2:0] S_DN_CMP  = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [AW-1:0]       pos_ff, pos_in;
   entry_type           cur_ff, cur_in;
   entry_type           top_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   rsp_type             rsp_ff, rsp_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   entry_type           wr_data;
   logic [AW-1:0]       rd_a_addr;
   logic [AW-1:0]       rd_b_addr;
   entry_type           rd_a_data;
   entry_type           rd_b_data;

   logic [CW-1:0]       cnt_dec;
   logic [XW-1:0]       cnt_x;
   logic [EW-1:0]       cnt_ext;
   logic [AW-1:0]       parent;
   logic [XW-1:0]       left_w;
   logic [XW-1:0]       right_w;
   logic                take_right;
   entry_type           sel_data;
   logic [AW-1:0]       sel_idx;

   mhpq_store #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .AW         (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // index arithmetic of the heap tree
   assign cnt_dec = count_ff - CW'(1);
   assign cnt_x   = XW'(count_ff);
   assign cnt_ext = EW'(count_ff);
   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign left_w  = {1'b0, pos_ff, 1'b1};
   assign right_w = left_w + XW'(1);

   // pick the smaller child, the right one on equal keys
   assign take_right = (right_w < cnt_x) && !(rd_a_data.end_stamp < rd_b_data.end_stamp);
   assign sel_data   = take_right ? rd_b_data : rd_a_data;
   assign sel_idx    = take_right ? right_w[AW-1:0] : left_w[AW-1:0];

   // sequence one request through the memory
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = cur_ff;
      rd_a_addr     = cnt_dec[AW-1:0];
      rd_b_addr     = right_w[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               if (req_item.func == FUNC_PUSH) begin
                  if (count_ff == CW'(HEAP_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     cur_in.start_stamp = req_item.start_stamp;
                     cur_in.end_stamp   = req_item.end_stamp;
                     pos_in             = count_ff[AW-1:0];
                     count_in           = count_ff + CW'(1);
                     state_in           = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     // the last entry is read here and moves to the root
                     count_in = cnt_dec;
                     state_in = (cnt_dec == '0) ? S_RESP : S_DN_LAST;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_a_addr = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cur_ff.end_stamp < rd_a_data.end_stamp) begin
               // move the parent down into the hole and climb
               wr_data  = rd_a_data;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DN_LAST: begin
            cur_in   = rd_a_data;
            pos_in   = '0;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (left_w >= cnt_x) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_a_addr = left_w[AW-1:0];
               rd_b_addr = right_w[AW-1:0];
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (cur_ff.end_stamp > sel_data.end_stamp) begin
               // move the chosen child up into the hole and sink
               wr_data  = sel_data;
               pos_in   = sel_idx;
               state_in = S_DN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.top_start      = (count_ff == '0) ? '0 : top_ff.start_stamp;
            rsp_in.top_end        = (count_ff == '0) ? '0 : top_ff.end_stamp;
            rsp_in.entry_count    = cnt_ext[COUNT_W-1:0];
            rsp_in.status         = status_ff;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload; mirror every write of the root slot
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- rtl/core/mhpq_checker.sv -----
// Port-level checks of the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue_macros.svh.
`include "min_heap_priority_queue_macros.svh"

module mhpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input mhpq_pkg::rsp_type rsp_item
);
   import mhpq_pkg::*;

   // leave reset idle with no result pending
   `MHPQ_ASSERT_ALWAYS(a_reset_idle, clock, (reset |=> (!busy && !rsp_strobe)), "not idle after reset")

   // a transfer keeps the block busy until its result
   `MHPQ_ASSERT(a_accept_busy, clock, reset, ((start && !busy) |=> busy), "transfer did not raise busy")

   // a result only closes a busy period
   `MHPQ_ASSERT(a_strobe_after_busy, clock, reset, (rsp_strobe |-> $past(busy)), "result without request")

   // one result per request, never two in a row
   `MHPQ_ASSERT(a_strobe_single, clock, reset, (rsp_strobe |=> !rsp_strobe), "result repeated")

   // a pop on an empty heap reports an empty heap
   `MHPQ_ASSERT(a_empty_zero, clock, reset, ((rsp_strobe && (rsp_item.status == ST_EMPTY)) |-> ((rsp_item.entry_count == '0) && (rsp_item.top_end == '0) && (rsp_item.top_start == '0))), "empty pop shows entries")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
